[sv/cab_pkg.sv]
// Shared types, constants and codes for the clipped alpha sprite blitter.
`timescale 1ns / 1ps

package cab_pkg;

    localparam int MAX_SCREEN_W = 256;
    localparam int MAX_SCREEN_H = 256;
    localparam int MAX_SPRITE_W = 128;
    localparam int MAX_SPRITE_H = 128;

    localparam int X_W         = $clog2(MAX_SCREEN_W);
    localparam int Y_W         = $clog2(MAX_SCREEN_H);
    localparam int ADDR_W      = X_W + Y_W;
    localparam int FRAME_DEPTH = MAX_SCREEN_W * MAX_SCREEN_H;
    localparam int COLOR_W     = 24;

    localparam logic [1:0] ACT_BLEND = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic        [8:0] screen_w;
        logic        [8:0] screen_h;
        logic        [7:0] sprite_w;
        logic        [7:0] sprite_h;
        logic signed [9:0] origin_x;
        logic signed [9:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic              landed;
        logic              is_blend;
        logic              is_write;
        logic [ADDR_W-1:0] addr;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [31:0]       word;
    } req_t;

endpackage

[sv/cab_locate.sv]
// Sprite column/row counters, screen mapping and clipping for blend items; others use frame_x/y.
`timescale 1ns / 1ps

module cab_locate import cab_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        accept,
    input  logic [1:0]  action,
    input  logic        first_pixel,
    input  logic [31:0] pixel_word,
    input  logic [7:0]  frame_x,
    input  logic [7:0]  frame_y,
    output req_t        req
);

    logic        [6:0]  col_reg;
    logic        [6:0]  row_reg;
    logic        [6:0]  col_next;
    logic        [6:0]  row_next;
    logic        [6:0]  col_cur;
    logic        [6:0]  row_cur;
    logic        [7:0]  eff_w;
    logic        [7:0]  eff_h;
    logic        [7:0]  col_inc;
    logic        [7:0]  row_inc;
    logic        [8:0]  clip_w;
    logic        [8:0]  clip_h;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic               in_screen;

    always_comb begin
        eff_w = (cfg.sprite_w == 8'd0) ? 8'd1 :
                (cfg.sprite_w > 8'(MAX_SPRITE_W)) ? 8'(MAX_SPRITE_W) : cfg.sprite_w;
        eff_h = (cfg.sprite_h == 8'd0) ? 8'd1 :
                (cfg.sprite_h > 8'(MAX_SPRITE_H)) ? 8'(MAX_SPRITE_H) : cfg.sprite_h;
        clip_w = (cfg.screen_w > 9'(MAX_SCREEN_W)) ? 9'(MAX_SCREEN_W) : cfg.screen_w;
        clip_h = (cfg.screen_h > 9'(MAX_SCREEN_H)) ? 9'(MAX_SCREEN_H) : cfg.screen_h;

        col_cur = first_pixel ? 7'd0 : col_reg;
        row_cur = first_pixel ? 7'd0 : row_reg;

        pos_x = 12'(cfg.origin_x) + signed'({5'd0, col_cur});
        pos_y = 12'(cfg.origin_y) + signed'({4'd0, eff_h}) - 12'sd1
                - signed'({5'd0, row_cur});
        in_screen = !pos_x[11] && !pos_y[11]
                    && (pos_x[10:0] < {2'b00, clip_w})
                    && (pos_y[10:0] < {2'b00, clip_h});

        col_inc = {1'b0, col_cur} + 8'd1;
        row_inc = {1'b0, row_cur} + 8'd1;
        if (col_inc >= eff_w) begin
            col_next = 7'd0;
            row_next = (row_inc >= eff_h) ? 7'd0 : row_inc[6:0];
        end else begin
            col_next = col_inc[6:0];
            row_next = row_cur;
        end

        req      = '0;
        req.word = pixel_word;
        case (action)
            ACT_BLEND: begin
                req.is_blend = 1'b1;
                req.landed   = in_screen;
                if (in_screen) begin
                    req.x    = pos_x[X_W-1:0];
                    req.y    = pos_y[Y_W-1:0];
                    req.addr = {pos_y[Y_W-1:0], pos_x[X_W-1:0]};
                end
            end
            ACT_WRITE: begin
                req.is_write = 1'b1;
                req.landed   = 1'b1;
                req.x        = frame_x;
                req.y        = frame_y;
                req.addr     = {frame_y, frame_x};
            end
            ACT_READ: begin
                req.landed = 1'b1;
                req.x      = frame_x;
                req.y      = frame_y;
                req.addr   = {frame_y, frame_x};
            end
            default: begin
                req.landed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 7'd0;
            row_reg <= 7'd0;
        end else if (accept && action == ACT_BLEND) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[sv/cab_frame_mem.sv]
// Frame store: one registered read port and one write port.
`timescale 1ns / 1ps

module cab_frame_mem import cab_pkg::*; (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [COLOR_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COLOR_W-1:0] wr_data
);

    logic [COLOR_W-1:0] mem [FRAME_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/clipped_alpha_sprite_blit.sv]
// Top level: clipped alpha sprite blit into an RGB frame store.
// Each item is registered in the first stage, second stage and output registers.
// Throughput: one item per cycle unless m_tready stalls; one frame store read and
// at most one write per item; a same-address read after a pending write is forwarded.
// Reset (synchronous, active low) clears pipeline valids, sprite counters and
// configuration to defaults; frame store contents are undefined until written.
`timescale 1ns / 1ps

module clipped_alpha_sprite_blit import cab_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_word[31:0], frame_x[39:32], frame_y[47:40]
    input  logic [2:0]  s_tuser,   // action[1:0], first_pixel[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_x[7:0], out_y[15:8], out_color[39:16]
    output logic        m_tuser,   // landed[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam logic [2:0] CFG_SCREEN_W = 3'd0;
    localparam logic [2:0] CFG_SCREEN_H = 3'd1;
    localparam logic [2:0] CFG_SPRITE_W = 3'd2;
    localparam logic [2:0] CFG_SPRITE_H = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd4;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd5;

    localparam cfg_t CFG_RESET = '{
        screen_w: 9'd256,
        screen_h: 9'd256,
        sprite_w: 8'd128,
        sprite_h: 8'd128,
        origin_x: 10'sd0,
        origin_y: 10'sd0
    };

    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [15:0] t;
        t = v + {8'd0, v[15:8]} + 16'd1;
        return t[15:8];
    endfunction

    cfg_t               cfg_reg;
    req_t               req;
    logic               accept;
    logic               en1;
    logic               en2;

    logic               s1_valid_reg;
    req_t               s1_req_reg;
    logic               s1_fwd_valid_reg;
    logic [COLOR_W-1:0] s1_fwd_color_reg;
    logic [COLOR_W-1:0] rd_color;
    logic [COLOR_W-1:0] d_cur;
    logic [7:0]         alpha;
    logic [7:0]         alpha_inv;
    logic [15:0]        sum_r_next;
    logic [15:0]        sum_g_next;
    logic [15:0]        sum_b_next;

    logic               s2_valid_reg;
    req_t               s2_req_reg;
    logic [15:0]        s2_sum_r_reg;
    logic [15:0]        s2_sum_g_reg;
    logic [15:0]        s2_sum_b_reg;
    logic [COLOR_W-1:0] s2_color_reg;
    logic [COLOR_W-1:0] s2_color;
    logic               s2_writes;
    logic               wr_en;

    logic               out_valid_reg;
    logic               out_landed_reg;
    logic [7:0]         out_x_reg;
    logic [7:0]         out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SCREEN_W: cfg_reg.screen_w <= cfg_data[8:0];
                CFG_SCREEN_H: cfg_reg.screen_h <= cfg_data[8:0];
                CFG_SPRITE_W: cfg_reg.sprite_w <= cfg_data[7:0];
                CFG_SPRITE_H: cfg_reg.sprite_h <= cfg_data[7:0];
                CFG_ORIGIN_X: cfg_reg.origin_x <= signed'(cfg_data);
                CFG_ORIGIN_Y: cfg_reg.origin_y <= signed'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign en2      = !out_valid_reg || m_tready;
    assign en1      = !s2_valid_reg || en2;
    assign s_tready = !s1_valid_reg || en1;
    assign accept   = s_tvalid && s_tready;

    cab_locate u_locate (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .action      (s_tuser[1:0]),
        .first_pixel (s_tuser[2]),
        .pixel_word  (s_tdata[31:0]),
        .frame_x     (s_tdata[39:32]),
        .frame_y     (s_tdata[47:40]),
        .req         (req)
    );

    cab_frame_mem u_frame_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (req.addr),
        .rd_data (rd_color),
        .wr_en   (wr_en),
        .wr_addr (s2_req_reg.addr),
        .wr_data (s2_color)
    );

    always_comb begin
        s2_color  = s2_req_reg.is_blend ?
                    {div255(s2_sum_r_reg), div255(s2_sum_g_reg), div255(s2_sum_b_reg)} :
                    s2_color_reg;
        s2_writes = s2_req_reg.landed && (s2_req_reg.is_blend || s2_req_reg.is_write);
        wr_en     = en2 && s2_valid_reg && s2_writes;

        if (s2_valid_reg && s2_writes && s2_req_reg.addr == s1_req_reg.addr) begin
            d_cur = s2_color;
        end else if (s1_fwd_valid_reg) begin
            d_cur = s1_fwd_color_reg;
        end else begin
            d_cur = rd_color;
        end

        alpha      = s1_req_reg.word[31:24];
        alpha_inv  = 8'd255 - alpha;
        sum_r_next = 16'(alpha) * 16'(s1_req_reg.word[23:16])
                     + 16'(alpha_inv) * 16'(d_cur[23:16]);
        sum_g_next = 16'(alpha) * 16'(s1_req_reg.word[15:8])
                     + 16'(alpha_inv) * 16'(d_cur[15:8]);
        sum_b_next = 16'(alpha) * 16'(s1_req_reg.word[7:0])
                     + 16'(alpha_inv) * 16'(d_cur[7:0]);
    end

    // Load the first stage item and track writes that land after its frame read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s1_fwd_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
            if (accept) begin
                s1_req_reg       <= req;
                s1_fwd_valid_reg <= wr_en && (s2_req_reg.addr == req.addr);
                s1_fwd_color_reg <= s2_color;
            end
        end else if (wr_en && s2_req_reg.addr == s1_req_reg.addr) begin
            s1_fwd_valid_reg <= 1'b1;
            s1_fwd_color_reg <= s2_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en1) begin
            s2_valid_reg <= s1_valid_reg;
            s2_req_reg   <= s1_req_reg;
            s2_sum_r_reg <= sum_r_next;
            s2_sum_g_reg <= sum_g_next;
            s2_sum_b_reg <= sum_b_next;
            s2_color_reg <= s1_req_reg.is_write ? s1_req_reg.word[COLOR_W-1:0] : d_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en2) begin
            out_valid_reg  <= s2_valid_reg;
            out_landed_reg <= s2_req_reg.landed;
            out_x_reg      <= s2_req_reg.x;
            out_y_reg      <= s2_req_reg.y;
            out_color_reg  <= s2_req_reg.landed ? s2_color : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_landed_reg;
    assign m_tdata  = {out_color_reg, out_y_reg, out_x_reg};

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item missing from first stage");

    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !en1) |=> (s1_valid_reg && $stable(s1_req_reg.addr)))
        else $error("first stage item changed while stalled");

    a_s2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !en2) |=> (s2_valid_reg && $stable(s2_color)))
        else $error("second stage color changed while stalled");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("item that did not land carries nonzero data");

endmodule
